// ===== rtl/tcp_flow_sentinel_fragment_selector_top_assert.svh =====
// Assertion macros for the TCP flow sentinel fragment selector.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef TCP_FLOW_SENTINEL_FRAGMENT_SELECTOR_TOP_ASSERT_SVH
`define TCP_FLOW_SENTINEL_FRAGMENT_SELECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TFS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfs: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TFS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfs: next-cycle check failed");

`endif

// ===== rtl/tfs_pkg.sv =====
// Shared types and constants for the TCP flow sentinel fragment selector.
// No dependencies; imported by tfs_cell and the top level.
package tfs_pkg;

    localparam int FLOW_ENTRIES_DEFAULT = 64;

    localparam logic [15:0] PORT_TLS  = 16'd443;
    localparam logic [15:0] PORT_HTTP = 16'd80;

    localparam logic [7:0]  TLS_HANDSHAKE    = 8'h16;
    localparam logic [7:0]  TLS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] TLS_MIN_LEN      = 16'd6;
    localparam logic [7:0]  HTTP_CHAR_G      = 8'h47;
    localparam logic [7:0]  HTTP_CHAR_E      = 8'h45;
    localparam logic [7:0]  HTTP_CHAR_T      = 8'h54;
    localparam logic [15:0] HTTP_MIN_LEN     = 16'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] REG_FRAGMENT_SENTINEL = 2'd0;
    localparam logic [1:0] REG_FRAGMENT_ALL      = 2'd1;
    localparam logic [1:0] REG_PACKET_OFFSET     = 2'd2;

    typedef enum logic [3:0] {
        ACT_BYPASS     = 4'd0,
        ACT_LATER_FRAG = 4'd1,
        ACT_SYN        = 4'd2,
        ACT_UNTRACKED  = 4'd3,
        ACT_ALL        = 4'd4,
        ACT_SENTINEL   = 4'd5,
        ACT_WAITING    = 4'd6,
        ACT_UNSET      = 4'd7,
        ACT_OFFSET     = 4'd8,
        ACT_COUNTING   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_UPDATE,
        CMD_RETIRE
    } cmd_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // Lookup probe that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic        live;
        logic        found;
        logic        seen;
        logic [15:0] count;
        logic        free;
    } probe_t;

    // Write command broadcast to all cells; the addressed cell applies it.
    typedef struct packed {
        cmd_op_t     op;
        logic        seen;
        logic [15:0] count;
    } cmd_t;

endpackage

// ===== rtl/tcp_flow_sentinel_fragment_selector_top.sv =====
// Top level of the TCP flow sentinel fragment selector: control, registers
// and the chain of flow table cells. Depends on tfs_pkg and tfs_cell.
//
// Usage: a packet header summary is transferred in at a rising edge with start
// high and busy low. Later IP fragments and packets to ports other than 443 or
// 80 answer in the next cycle and leave busy low. For any other packet, once
// the key is captured at transfer, the lookup probe walks the
// chain of flow cells, one cell per cycle, collecting the matching entry and
// the lowest free entry, and the decision and table write follow when it
// leaves the last cell. busy stays high for that walk. Each result is shown
// for exactly one cycle with done high and cannot be stalled, so the receiver
// must take it on that cycle. The flow table is empty right after reset with
// no clearing pass. The user must keep configuration writes to idle (unenforced).
module tcp_flow_sentinel_fragment_selector_top
    import tfs_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic        later_fragment,
    input  logic        syn_flag,
    input  logic [15:0] payload_length,
    input  logic [7:0]  payload_first,
    input  logic [7:0]  payload_second,
    input  logic [7:0]  payload_third,
    input  logic [7:0]  payload_sixth,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        out_port,
    output logic [3:0]  action,
    output logic        table_full
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

    // Configuration registers.
    logic        frag_sentinel_reg;
    logic        frag_all_reg;
    logic [15:0] packet_offset_reg;

    // Packet held for the duration of the walk.
    logic [63:0] key_addrs_reg;
    logic [31:0] key_ports_reg;
    logic        syn_reg;
    logic        sentinel_reg;

    state_t state_reg;
    state_t state_next;
    logic   launch_reg;
    logic   launch_next;

    logic    done_reg;
    logic    done_next;
    logic    out_port_reg;
    logic    out_port_next;
    action_t action_reg;
    action_t action_next;
    logic    table_full_reg;
    logic    table_full_next;

    logic accept;
    logic tracked_port;
    logic sentinel_tls;
    logic sentinel_http;
    logic sentinel_in;

    // Cell chain links: element k feeds cell k; the last one returns to control.
    probe_t           probe_chain [FLOW_ENTRIES+1];
    logic [IDX_W-1:0] found_chain [FLOW_ENTRIES+1];
    logic [IDX_W-1:0] free_chain  [FLOW_ENTRIES+1];
    probe_t           probe_end;

    cmd_t             cmd;
    logic [IDX_W-1:0] cmd_idx;

    logic        seen_new;
    logic [15:0] count_new;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign tracked_port  = (dest_port == PORT_TLS) || (dest_port == PORT_HTTP);
    assign sentinel_tls  = (payload_length >= TLS_MIN_LEN) && (payload_first == TLS_HANDSHAKE)
                           && (payload_sixth == TLS_CLIENT_HELLO);
    assign sentinel_http = (payload_length >= HTTP_MIN_LEN) && (payload_first == HTTP_CHAR_G)
                           && (payload_second == HTTP_CHAR_E)
                           && (payload_third == HTTP_CHAR_T);
    assign sentinel_in   = (dest_port == PORT_TLS) ? sentinel_tls : sentinel_http;

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_sentinel_reg <= 1'b1;
            frag_all_reg      <= 1'b0;
            packet_offset_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAGMENT_SENTINEL: frag_sentinel_reg <= cfg_data[0];
                REG_FRAGMENT_ALL:      frag_all_reg      <= cfg_data[0];
                REG_PACKET_OFFSET:     packet_offset_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Packet capture at transfer time.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_addrs_reg <= {source_address, destination_address};
            key_ports_reg <= {source_port, dest_port};
            syn_reg       <= syn_flag;
            sentinel_reg  <= sentinel_in;
        end
    end

    // The probe enters cell 0 in the cycle after transfer, once the key is held.
    assign probe_chain[0] = '{live: launch_reg, found: 1'b0, seen: 1'b0,
                              count: 16'd0, free: 1'b0};
    assign found_chain[0] = '0;
    assign free_chain[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < FLOW_ENTRIES; gi++)
        begin : g_cell
            tfs_cell #(
                .IDX_W      (IDX_W),
                .CELL_INDEX (gi)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .key_addrs     (key_addrs_reg),
                .key_ports     (key_ports_reg),
                .probe_in      (probe_chain[gi]),
                .found_idx_in  (found_chain[gi]),
                .free_idx_in   (free_chain[gi]),
                .probe_out     (probe_chain[gi+1]),
                .found_idx_out (found_chain[gi+1]),
                .free_idx_out  (free_chain[gi+1]),
                .cmd           (cmd),
                .cmd_idx       (cmd_idx)
            );
        end
    endgenerate

    assign probe_end = probe_chain[FLOW_ENTRIES];

    // The post-sentinel view of the matched entry.
    assign seen_new  = probe_end.seen || sentinel_reg;
    assign count_new = (probe_end.count == COUNT_MAX) ? probe_end.count
                                                      : probe_end.count + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_port_reg   <= out_port_next;
        action_reg     <= action_next;
        table_full_reg <= table_full_next;
    end

    // Next state, result and table write command.
    always_comb
    begin
        state_next      = state_reg;
        launch_next     = 1'b0;
        done_next       = 1'b0;
        out_port_next   = 1'b0;
        action_next     = ACT_BYPASS;
        table_full_next = 1'b0;
        cmd             = '{op: CMD_NONE, seen: seen_new, count: probe_end.count};
        cmd_idx         = found_chain[FLOW_ENTRIES];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (later_fragment)
                    begin
                        done_next   = 1'b1;
                        action_next = ACT_LATER_FRAG;
                    end
                    else if (!tracked_port)
                    begin
                        done_next   = 1'b1;
                        action_next = ACT_BYPASS;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (probe_end.live)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (syn_reg)
                    begin
                        action_next = ACT_SYN;
                        if (!probe_end.found)
                        begin
                            if (probe_end.free)
                            begin
                                cmd.op  = CMD_INSERT;
                                cmd_idx = free_chain[FLOW_ENTRIES];
                            end
                            else
                            begin
                                table_full_next = 1'b1;
                            end
                        end
                    end
                    else if (!probe_end.found)
                    begin
                        action_next = ACT_UNTRACKED;
                    end
                    else if (frag_all_reg && seen_new)
                    begin
                        out_port_next = 1'b1;
                        action_next   = ACT_ALL;
                        cmd.op        = CMD_UPDATE;
                    end
                    else if (sentinel_reg && frag_sentinel_reg)
                    begin
                        out_port_next = 1'b1;
                        action_next   = ACT_SENTINEL;
                        cmd.op        = CMD_RETIRE;
                    end
                    else if (!seen_new)
                    begin
                        action_next = ACT_WAITING;
                    end
                    else if (packet_offset_reg == 16'd0)
                    begin
                        action_next = ACT_UNSET;
                        cmd.op      = CMD_RETIRE;
                    end
                    else if (count_new == packet_offset_reg)
                    begin
                        out_port_next = 1'b1;
                        action_next   = ACT_OFFSET;
                        cmd.op        = CMD_RETIRE;
                    end
                    else
                    begin
                        action_next = ACT_COUNTING;
                        cmd.op      = CMD_UPDATE;
                        cmd.count   = count_new;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign out_port   = out_port_reg;
    assign action     = action_reg;
    assign table_full = table_full_reg;

`include "tcp_flow_sentinel_fragment_selector_top_assert.svh"

    // A launched probe always belongs to a walk in progress.
    `TFS_ASSERT_IMP(a_launch_in_walk, launch_reg, state_reg == ST_WALK)
    // The walk ends as soon as the probe leaves the last cell.
    `TFS_ASSERT_NXT(a_walk_ends, probe_end.live, !busy && done)
    // A later fragment is answered in the very next cycle.
    `TFS_ASSERT_NXT(a_later_fast, accept && later_fragment, done && action == ACT_LATER_FRAG)
    // Only the three fragmenting decisions send a packet to port 1.
    `TFS_ASSERT_IMP(a_port_one, done && out_port,
        action == ACT_ALL || action == ACT_SENTINEL || action == ACT_OFFSET)
    // A full table is reported only for a SYN.
    `TFS_ASSERT_IMP(a_full_syn, done && table_full, action == ACT_SYN)

endmodule

// ===== rtl/tfs_cell.sv =====
// One flow table entry of the TCP flow sentinel fragment selector.
// Depends on tfs_pkg; instantiated in a chain by the top level.
module tfs_cell
    import tfs_pkg::*;
#(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      key_addrs,
    input  logic [31:0]      key_ports,
    input  probe_t           probe_in,
    input  logic [IDX_W-1:0] found_idx_in,
    input  logic [IDX_W-1:0] free_idx_in,
    output probe_t           probe_out,
    output logic [IDX_W-1:0] found_idx_out,
    output logic [IDX_W-1:0] free_idx_out,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] cmd_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic        valid_reg;
    logic [63:0] addrs_reg;
    logic [31:0] ports_reg;
    logic        seen_reg;
    logic [15:0] count_reg;

    probe_t           probe_reg;
    probe_t           probe_next;
    logic [IDX_W-1:0] found_idx_reg;
    logic [IDX_W-1:0] found_idx_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;

    logic match;
    logic hit;

    assign match = valid_reg && (addrs_reg == key_addrs) && (ports_reg == key_ports);
    assign hit   = (cmd.op != CMD_NONE) && (cmd_idx == MY_IDX);

    // The first matching entry and the first free entry are picked up on the way.
    always_comb
    begin
        probe_next     = probe_in;
        found_idx_next = found_idx_in;
        free_idx_next  = free_idx_in;
        if (probe_in.live && !probe_in.found && match)
        begin
            probe_next.found = 1'b1;
            probe_next.seen  = seen_reg;
            probe_next.count = count_reg;
            found_idx_next   = MY_IDX;
        end
        if (probe_in.live && !probe_in.free && !valid_reg)
        begin
            probe_next.free = 1'b1;
            free_idx_next   = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg     <= '0;
            found_idx_reg <= '0;
            free_idx_reg  <= '0;
        end
        else
        begin
            probe_reg     <= probe_next;
            found_idx_reg <= found_idx_next;
            free_idx_reg  <= free_idx_next;
        end
    end

    assign probe_out     = probe_reg;
    assign found_idx_out = found_idx_reg;
    assign free_idx_out  = free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            if (cmd.op == CMD_INSERT)
            begin
                valid_reg <= 1'b1;
            end
            else if (cmd.op == CMD_RETIRE)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && (cmd.op == CMD_INSERT))
        begin
            addrs_reg <= key_addrs;
            ports_reg <= key_ports;
            seen_reg  <= 1'b0;
            count_reg <= 16'd0;
        end
        else if (hit && (cmd.op == CMD_UPDATE))
        begin
            seen_reg  <= cmd.seen;
            count_reg <= cmd.count;
        end
    end

endmodule
